// ===== hw/rtl/substring_match_scanner_core_assert.svh =====
// Assertion macros shared by the substring match scanner RTL.
// Included by modules that check their own logic; needs clk and arst_n in scope.
`ifndef SUBSTRING_MATCH_SCANNER_CORE_ASSERT_SVH
`define SUBSTRING_MATCH_SCANNER_CORE_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define SMSC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SMSC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/smsc_pkg.sv =====
// Package of the substring match scanner: sizes, codes and the types that
// pass between the front, queue and back. No dependencies.
`default_nettype none

package smsc_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int COUNT_BITS  = 32;

	localparam int KEY_BYTES   = 16;
	localparam int REG_BITS    = 64;
	localparam int LEN_BITS    = $clog2(MAX_PATTERN + 1);
	localparam int LEN_REG_BITS = 5;
	localparam int OFFSET_BITS = 32;
	localparam int TOTAL_BITS  = 32;
	localparam int CFG_IDX_BITS = 2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
	localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_PATTERN_LOW  = 2'd0,
		REG_PATTERN_HIGH = 2'd1,
		REG_PATTERN_LEN  = 2'd2
	} cfg_index_t;

	typedef enum logic {
		KIND_MATCH = 1'b0,
		KIND_TOTAL = 1'b1
	} result_kind_t;

	typedef struct packed {
		logic [REG_BITS-1:0]     pattern_low;
		logic [REG_BITS-1:0]     pattern_high;
		logic [LEN_REG_BITS-1:0] pattern_length;
	} cfg_t;

	// One request handed from the front to the back.
	typedef struct packed {
		logic                   hit;
		logic                   last;
		logic [OFFSET_BITS-1:0] offset;
		logic [TOTAL_BITS-1:0]  total;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/smsc_byte_if.sv =====
// Input channel of the substring match scanner: one stream byte per request.
// Depends on nothing.
`default_nettype none

interface smsc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/smsc_result_if.sv =====
// Output channel of the substring match scanner: match and total results.
// Depends on nothing.
`default_nettype none

interface smsc_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [31:0] match_offset;
	logic [31:0] match_total;
	logic        run_end;

	modport source (output valid, output result_kind, output match_offset,
		output match_total, output run_end, input ready);
	modport sink (input valid, input result_kind, input match_offset,
		input match_total, input run_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/substring_match_scanner_core.sv =====
// Top level of the substring match scanner: configuration registers and the
// front, queue and back. Depends on smsc_pkg, both channel interfaces and the
// front, queue and back modules.
//
// Use: the keyword (1 to 16 bytes) is written through cfg_we/cfg_index/cfg_wdata
// as two packed byte registers and a length, while the block is idle. The
// stream enters on "bytes", one byte per request, with last_byte on its final
// byte. Every match, overlapping ones included, gives a result on "results"
// with the offset of its first byte; the last byte also gives a total result
// with the match count of that stream, after any match ending on that byte.
// A byte's first result passes through the request queue and then the output register.
// The block takes one byte per cycle unless the queue is full; only a byte that
// completes a match and ends the stream gives two results, which the queue absorbs.
// When the receiver stalls, the output register holds its result and the
// four-entry queue fills; bytes are refused only once the queue is full.
// Reset clears window, offset, count and queue, and sets the keyword to zero
// bytes with length one.
`default_nettype none

module substring_match_scanner_core (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire [smsc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire [smsc_pkg::REG_BITS-1:0]      cfg_wdata,
	smsc_byte_if.sink                         bytes,
	smsc_result_if.source                     results
);
	import smsc_pkg::*;

	cfg_t    cfg_q;
	job_t    push_job;
	job_t    head;
	q_stat_t q_stat;
	logic    push;
	logic    pop;

	// Configuration registers. Indexes outside the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_low    <= '0;
			cfg_q.pattern_high   <= '0;
			cfg_q.pattern_length <= LEN_REG_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LOW: begin
					cfg_q.pattern_low <= cfg_wdata;
				end
				REG_PATTERN_HIGH: begin
					cfg_q.pattern_high <= cfg_wdata;
				end
				REG_PATTERN_LEN: begin
					cfg_q.pattern_length <= cfg_wdata[LEN_REG_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The front classifies each byte and pushes a request only when it has a
	// match or ends the stream.
	smsc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.bytes  (bytes),
		.q_stat (q_stat),
		.push   (push),
		.job    (push_job)
	);

	smsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	// The back drains requests into the registered output channel.
	smsc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_stat  (q_stat),
		.pop     (pop),
		.results (results)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/smsc_front.sv =====
// Front of the scanner: takes bytes, shifts the window, compares it with the
// keyword and keeps offset and count. Depends on smsc_pkg and smsc_byte_if.
`default_nettype none

module smsc_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  smsc_pkg::cfg_t       cfg,
	smsc_byte_if.sink            bytes,
	input  smsc_pkg::q_stat_t    q_stat,
	output logic                 push,
	output smsc_pkg::job_t       job
);
	import smsc_pkg::*;

	logic [7:0] win_q [MAX_PATTERN];
	logic [7:0] win_new [MAX_PATTERN];
	logic [7:0] key [KEY_BYTES];
	logic [7:0] akey [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] eq;
	logic [MAX_PATTERN-1:0] mask;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [COUNT_BITS-1:0]  cnt_q;
	logic [COUNT_BITS-1:0]  cnt_next;
	logic [LEN_BITS-1:0]    len;
	logic [LEN_BITS-1:0]    len_m1;
	logic [OFFSET_BITS-1:0] len_m1_ext;
	logic                   accept;
	logic                   hit;
	logic                   long_enough;

	assign bytes.ready = !q_stat.full;
	assign accept      = bytes.valid && bytes.ready;

	// Length in use: zero counts as one, anything above the window as the window.
	always_comb begin
		if (cfg.pattern_length == '0) begin
			len = LEN_BITS'(1);
		end else if (LEN_REG_BITS'(cfg.pattern_length) > LEN_REG_BITS'(MAX_PATTERN)) begin
			len = LEN_BITS'(MAX_PATTERN);
		end else begin
			len = LEN_BITS'(cfg.pattern_length);
		end
		len_m1     = len - LEN_BITS'(1);
		len_m1_ext = OFFSET_BITS'(len_m1);
	end

	// Keyword byte k lines up with window entry len-1-k.
	always_comb begin
		logic [LEN_BITS-1:0] idx;
		for (int k = 0; k < 8; k++) begin
			key[k]     = cfg.pattern_low[8*k +: 8];
			key[k + 8] = cfg.pattern_high[8*k +: 8];
		end
		win_new[0] = bytes.data_byte;
		for (int j = 1; j < MAX_PATTERN; j++) begin
			win_new[j] = win_q[j-1];
		end
		for (int j = 0; j < MAX_PATTERN; j++) begin
			idx     = len_m1 - LEN_BITS'(j);
			akey[j] = key[idx[3:0]];
			eq[j]   = (win_new[j] == akey[j]);
			mask[j] = (LEN_BITS'(j) < len);
		end
	end

	assign long_enough = (pos_q == OFFSET_MAX) || (pos_q >= len_m1_ext);
	assign hit         = long_enough && (&(eq | ~mask));
	assign cnt_next    = (hit && cnt_q != COUNT_MAX) ? cnt_q + COUNT_BITS'(1) : cnt_q;

	always_comb begin
		job.hit    = hit;
		job.last   = bytes.last_byte;
		job.offset = (pos_q == OFFSET_MAX) ? OFFSET_MAX : pos_q - len_m1_ext;
		if (COUNT_BITS > TOTAL_BITS && cnt_next > COUNT_BITS'({TOTAL_BITS{1'b1}})) begin
			job.total = '1;
		end else begin
			job.total = TOTAL_BITS'(cnt_next);
		end
	end

	assign push = accept && (hit || bytes.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cnt_q <= '0;
			for (int j = 0; j < MAX_PATTERN; j++) begin
				win_q[j] <= '0;
			end
		end else if (accept) begin
			if (bytes.last_byte) begin
				pos_q <= '0;
				cnt_q <= '0;
				for (int j = 0; j < MAX_PATTERN; j++) begin
					win_q[j] <= '0;
				end
			end else begin
				if (pos_q != OFFSET_MAX) begin
					pos_q <= pos_q + OFFSET_BITS'(1);
				end
				cnt_q <= cnt_next;
				for (int j = 0; j < MAX_PATTERN; j++) begin
					win_q[j] <= win_new[j];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/smsc_queue.sv =====
// Short request queue between front and back of the scanner.
// Depends on smsc_pkg.
`default_nettype none

module smsc_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  smsc_pkg::job_t       push_job,
	input  wire                  pop,
	output smsc_pkg::job_t       head,
	output smsc_pkg::q_stat_t    stat
);
	import smsc_pkg::*;

	job_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QCNT_BITS-1:0] cnt_q;

	assign head       = mem_q[rd_q];
	assign stat.full  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_BITS'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/smsc_back.sv =====
// Back of the scanner: turns queued requests into match and total results
// through an output register. Depends on smsc_pkg, smsc_result_if and the
// assertion macro header.
`default_nettype none
`include "substring_match_scanner_core_assert.svh"

module smsc_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  smsc_pkg::job_t       head,
	input  smsc_pkg::q_stat_t    q_stat,
	output logic                 pop,
	smsc_result_if.source        results
);
	import smsc_pkg::*;

	logic                   valid_q;
	logic                   valid_d;
	logic                   phase_q;
	logic                   phase_d;
	logic                   load;
	result_kind_t           kind_q;
	result_kind_t           kind_d;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [OFFSET_BITS-1:0] offset_d;
	logic [TOTAL_BITS-1:0]  total_q;
	logic [TOTAL_BITS-1:0]  total_d;
	logic                   run_end_q;
	logic                   run_end_d;

	assign load = !valid_q || results.ready;

	// A request with a match on the last byte gives two results; phase_q marks
	// that its match part has gone out and its total is next.
	always_comb begin
		pop       = 1'b0;
		phase_d   = phase_q;
		valid_d   = valid_q;
		kind_d    = kind_q;
		offset_d  = offset_q;
		total_d   = total_q;
		run_end_d = run_end_q;
		if (load) begin
			valid_d = !q_stat.empty;
			if (!q_stat.empty) begin
				if (!phase_q && head.hit) begin
					kind_d    = KIND_MATCH;
					offset_d  = head.offset;
					total_d   = '0;
					run_end_d = !head.last;
					if (head.last) begin
						phase_d = 1'b1;
					end else begin
						pop = 1'b1;
					end
				end else begin
					kind_d    = KIND_TOTAL;
					offset_d  = '0;
					total_d   = head.total;
					run_end_d = 1'b1;
					phase_d   = 1'b0;
					pop       = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q    <= kind_d;
		offset_q  <= offset_d;
		total_q   <= total_d;
		run_end_q <= run_end_d;
	end

	assign results.valid        = valid_q;
	assign results.result_kind  = kind_q;
	assign results.match_offset = offset_q;
	assign results.match_total  = total_q;
	assign results.run_end      = run_end_q;

	`SMSC_ASSERT(a_phase_head, phase_q |-> (!q_stat.empty && head.hit && head.last), "second half pending without a matching last-byte request")
	`SMSC_ASSERT(a_phase_out, phase_q |-> (valid_q && kind_q == KIND_MATCH && !run_end_q), "second half pending but output does not hold the match part")
	`SMSC_ASSERT(a_pop_nonempty, pop |-> !q_stat.empty, "pop from an empty queue")
	`SMSC_ASSERT(a_total_ends, (valid_q && kind_q == KIND_TOTAL) |-> run_end_q, "total result without run end")

endmodule

`default_nettype wire

// ===== verif/smsc_scan_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the substring match scanner: follows register writes and accepted bytes,
// predicts every match and total result and compares accepted results in order.
// Depends on smsc_pkg and the smsc_byte_if and smsc_result_if interfaces.

module smsc_scan_checker (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [smsc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire [smsc_pkg::REG_BITS-1:0]     cfg_wdata,
	smsc_byte_if                             bytes,
	smsc_result_if                           results,
	output int                               fail_count,
	output int                               pending_count,
	output int                               matches_checked,
	output int                               totals_checked
);
	import smsc_pkg::*;

	typedef struct packed {
		result_kind_t           kind;
		logic [OFFSET_BITS-1:0] offset;
		logic [TOTAL_BITS-1:0]  total;
		logic                   run_end;
	} scan_result_t;

	logic [REG_BITS-1:0]     key_low;
	logic [REG_BITS-1:0]     key_high;
	logic [LEN_REG_BITS-1:0] key_len;
	logic [7:0]              window [MAX_PATTERN];
	logic [OFFSET_BITS-1:0]  position;
	logic [COUNT_BITS-1:0]   found;
	scan_result_t            expected_q [$];
	int                      errors = 0;
	int                      n_match = 0;
	int                      n_total = 0;

	function automatic int unsigned active_length();
		if (key_len == 0)
			return 1;
		if (key_len > MAX_PATTERN)
			return MAX_PATTERN;
		return key_len;
	endfunction

	function automatic logic [7:0] keyword_byte(input int unsigned k);
		if (k < 8)
			return key_low[8*k +: 8];
		return key_high[8*(k-8) +: 8];
	endfunction

	// Shifts one byte into the window and queues the results it causes.
	function automatic void scan_byte(input logic [7:0] value, input logic end_of_stream);
		int unsigned  klen;
		int           i;
		logic         hit;
		logic [63:0]  sum;
		scan_result_t r;
		klen = active_length();
		for (i = MAX_PATTERN - 1; i > 0; i--)
			window[i] = window[i - 1];
		window[0] = value;
		// A match needs a full keyword of this stream; a saturated offset always qualifies.
		hit = (position == OFFSET_MAX) || (position >= klen - 1);
		for (i = 0; i < klen; i++)
			if (window[klen - 1 - i] != keyword_byte(i))
				hit = 1'b0;
		if (hit) begin
			if (found != COUNT_MAX)
				found = found + 1'b1;
			r.kind    = KIND_MATCH;
			r.offset  = (position == OFFSET_MAX) ? OFFSET_MAX : position - (klen - 1);
			r.total   = '0;
			r.run_end = !end_of_stream;
			expected_q.push_back(r);
		end
		if (position != OFFSET_MAX)
			position = position + 1'b1;
		if (end_of_stream) begin
			sum       = 64'(found);
			r.kind    = KIND_TOTAL;
			r.offset  = '0;
			r.total   = (sum > 64'(OFFSET_MAX)) ? OFFSET_MAX : sum[TOTAL_BITS-1:0];
			r.run_end = 1'b1;
			expected_q.push_back(r);
			window   = '{default: 8'h00};
			position = '0;
			found    = '0;
		end
	endfunction

	function automatic void compare_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		scan_result_t want;
		if (!arst_n) begin
			key_low  = '0;
			key_high = '0;
			key_len  = LEN_REG_BITS'(1);
			window   = '{default: 8'h00};
			position = '0;
			found    = '0;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PATTERN_LOW:  key_low  = cfg_wdata;
					REG_PATTERN_HIGH: key_high = cfg_wdata;
					REG_PATTERN_LEN:  key_len  = cfg_wdata[LEN_REG_BITS-1:0];
					default: ;
				endcase
			end
			if (bytes.valid && bytes.ready)
				scan_byte(bytes.data_byte, bytes.last_byte);
			if (results.valid && results.ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected result, expected none, actual kind %0d offset %0h total %0h end %0b",
						$time, results.result_kind, results.match_offset, results.match_total,
						results.run_end);
				end else begin
					want = expected_q.pop_front();
					compare_field("result_kind", want.kind, results.result_kind);
					compare_field("match_offset", want.offset, results.match_offset);
					compare_field("match_total", want.total, results.match_total);
					compare_field("run_end", want.run_end, results.run_end);
					if (want.kind == KIND_MATCH)
						n_match++;
					else
						n_total++;
				end
			end
		end
		fail_count      <= errors;
		pending_count   <= expected_q.size();
		matches_checked <= n_match;
		totals_checked  <= n_total;
	end

endmodule

// ===== verif/substring_match_scanner_core_test.sv =====
`timescale 1ns / 1ps
// Testbench top of the substring match scanner core: clock, reset, keyword writes, byte
// streams and result back-pressure; smsc_scan_checker does the checking.
// Depends on smsc_pkg, both channel interfaces, the core and the checker.

module substring_match_scanner_core_test;
	import smsc_pkg::*;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 8;
	localparam int RANDOM_BYTES   = 1400;
	// Extra wait after the last predicted result, for bytes that give no result.
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 80;
	localparam int PRESSURE_BYTES = 24;
	localparam int IDLE_LIMIT     = 2000;
	// Index 3 has no register behind it; a write there must change nothing.
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [REG_BITS-1:0]     cfg_wdata;

	smsc_byte_if   byte_ch ();
	smsc_result_if result_ch ();

	int fail_count;
	int pending_count;
	int matches_checked;
	int totals_checked;
	int bytes_sent = 0;
	int streams_sent = 0;
	int keywords_set = 0;
	int idle_cycles = 0;

	// Handshake between the stimulus and the result sink for the long hold-off.
	bit hold_sink = 1'b0;
	bit sink_holding = 1'b0;

	// The keyword as last written, kept so that streams can be built around it.
	logic [7:0] key_bytes [MAX_PATTERN];
	int         key_used;
	logic [7:0] stream_buf [$];

	substring_match_scanner_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.bytes    (byte_ch),
		.results  (result_ch)
	);

	smsc_scan_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.bytes          (byte_ch),
		.results        (result_ch),
		.fail_count     (fail_count),
		.pending_count  (pending_count),
		.matches_checked(matches_checked),
		.totals_checked (totals_checked)
	);

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	// Gap lengths for both sides: mostly none or short, now and then a long one.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// The run ends if neither channel moves a request or a result for too long.
	always @(posedge clk) begin
		if (!arst_n || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t ns: watchdog, %0d cycles with nothing accepted", $time, IDLE_LIMIT);
			$display("FAIL substring_match_scanner_core");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result sink. It alternates ready stretches, some of them long, with random stalls. On
	// request from the stimulus it holds ready low for HOLD_CYCLES so that the core's queue
	// fills and it has to refuse bytes. Every stretch waits for a clock edge, so ready is
	// never assigned twice in one time step.
	initial begin : result_sink
		int run;
		int gap;
		int i;
		result_ch.ready <= 1'b0;
		do
			@(posedge clk);
		while (arst_n !== 1'b1);
		forever begin
			if (hold_sink) begin
				sink_holding = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_holding = 1'b0;
			end else begin
				run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
				result_ch.ready <= 1'b1;
				i = 0;
				do begin
					@(posedge clk);
					i++;
				end while (i < run && !hold_sink);
				gap = idle_gap();
				if (gap > 0 && !hold_sink) begin
					result_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// Offers one byte and returns at the edge where the core takes it. The valid stays high,
	// so the caller must offer the next byte or drop valid in the same time step.
	task automatic offer_byte(input logic [7:0] value, input logic end_of_stream);
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= value;
		byte_ch.last_byte <= end_of_stream;
		@(posedge clk);
		while (byte_ch.ready !== 1'b1)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic pause_bytes(input int cycles);
		if (cycles > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Sends stream_buf as one stream, the last byte marked. A burst has no gaps at all.
	task automatic send_stream(input bit burst);
		int i;
		for (i = 0; i < stream_buf.size(); i++) begin
			offer_byte(stream_buf[i], i == stream_buf.size() - 1);
			if (!burst)
				pause_bytes(idle_gap());
		end
		streams_sent++;
	endtask

	// Drops valid and waits until every predicted result has come out, then lets the core
	// finish any byte that gave no result.
	task automatic wait_idle();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all registers, the unused index included, once the core is idle.
	task automatic program_keyword(input logic [REG_BITS-1:0] low_word,
		input logic [REG_BITS-1:0] high_word, input logic [REG_BITS-1:0] length_word);
		logic [LEN_REG_BITS-1:0] len_field;
		int                      k;
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_SPARE;
		cfg_wdata <= {$urandom, $urandom};
		@(posedge clk);
		cfg_index <= REG_PATTERN_LOW;
		cfg_wdata <= low_word;
		@(posedge clk);
		cfg_index <= REG_PATTERN_HIGH;
		cfg_wdata <= high_word;
		@(posedge clk);
		cfg_index <= REG_PATTERN_LEN;
		cfg_wdata <= length_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		// Only the low five bits count; zero acts as one and anything past 16 as 16.
		len_field = length_word[LEN_REG_BITS-1:0];
		if (len_field == 0)
			key_used = 1;
		else if (len_field > MAX_PATTERN)
			key_used = MAX_PATTERN;
		else
			key_used = len_field;
		for (k = 0; k < MAX_PATTERN; k++)
			key_bytes[k] = (k < 8) ? low_word[8*k +: 8] : high_word[8*(k-8) +: 8];
		keywords_set++;
	endtask

	// Builds a stream of at least size bytes: whole keywords, cut-off keywords, single keyword
	// bytes (which line up into overlapping matches), a filler byte and plain noise.
	task automatic make_stream(input int size, input logic [7:0] filler);
		int k;
		int cut;
		int r;
		stream_buf.delete();
		while (stream_buf.size() < size) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				for (k = 0; k < key_used; k++)
					stream_buf.push_back(key_bytes[k]);
			end else if (r < 35) begin
				cut = $urandom_range(0, key_used - 1);
				for (k = 0; k < cut; k++)
					stream_buf.push_back(key_bytes[k]);
			end else if (r < 70) begin
				stream_buf.push_back(key_bytes[$urandom_range(0, key_used - 1)]);
			end else if (r < 85) begin
				stream_buf.push_back(filler);
			end else begin
				stream_buf.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin : stimulus
		logic [REG_BITS-1:0]     low_word;
		logic [REG_BITS-1:0]     high_word;
		logic [REG_BITS-1:0]     length_word;
		logic [LEN_REG_BITS-1:0] len5;
		logic [7:0]              alphabet [2];
		logic [7:0]              pick;
		logic [7:0]              filler;
		int                      phase;
		int                      target;
		int                      size;
		int                      k;

		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= REG_PATTERN_LOW;
		cfg_wdata         <= '0;
		byte_ch.valid     <= 1'b0;
		byte_ch.data_byte <= 8'h00;
		byte_ch.last_byte <= 1'b0;
		key_bytes = '{default: 8'h00};
		key_used  = 1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The keyword after reset is a single zero byte: the lowest byte value matches at
		// offset 0, the highest one ends the stream with a total of one.
		stream_buf = '{8'h00, 8'hFF};
		send_stream(1'b1);

		// A length field of zero, with junk above its five bits, acts as length one. The
		// single byte both matches and ends the stream, so the match comes before the total.
		program_keyword(64'h0000_0000_0000_00FF, {$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFE0);
		stream_buf = '{8'hFF};
		send_stream(1'b1);

		// Keyword "aba". The first stream is too short and finds nothing, so its total is zero.
		// The second starts with "a", which must not complete a match with the earlier stream,
		// and then holds two overlapping matches, the second ending on the last byte.
		program_keyword(64'h0000_0000_0061_6261, 64'h0, 64'd3);
		stream_buf = '{8'h61, 8'h62};
		send_stream(1'b1);
		stream_buf = '{8'h61, 8'h62, 8'h61, 8'h62, 8'h61};
		send_stream(1'b1);

		// A length of 31 acts as the full 16 bytes; the stream is exactly the keyword.
		program_keyword({$urandom, $urandom}, {$urandom, $urandom}, 64'd31);
		stream_buf.delete();
		for (k = 0; k < key_used; k++)
			stream_buf.push_back(key_bytes[k]);
		send_stream(1'b1);

		// Back-pressure: every byte matches while the sink holds off, so the core's queue
		// fills and the byte channel stalls with a request still offered.
		program_keyword(64'h5A, 64'h0, 64'd1);
		hold_sink = 1'b1;
		while (!sink_holding)
			@(posedge clk);
		hold_sink = 1'b0;
		stream_buf.delete();
		repeat (PRESSURE_BYTES) stream_buf.push_back(8'h5A);
		send_stream(1'b1);

		// Random part. Each phase writes a new keyword, the first two at the register
		// extremes, then sends a few streams around it.
		target = bytes_sent + RANDOM_BYTES;
		phase = 0;
		while (bytes_sent < target) begin
			if (phase == 0) begin
				low_word    = '1;
				high_word   = '1;
				length_word = 64'd16;
			end else if (phase == 1) begin
				low_word    = '0;
				high_word   = '0;
				length_word = '1;
			end else begin
				// Keywords over two random bytes give repeats and overlaps often enough.
				alphabet[0] = 8'($urandom_range(0, 255));
				alphabet[1] = 8'($urandom_range(0, 255));
				for (k = 0; k < MAX_PATTERN; k++) begin
					pick = alphabet[$urandom_range(0, 1)];
					if (k < 8)
						low_word[8*k +: 8] = pick;
					else
						high_word[8*(k-8) +: 8] = pick;
				end
				case ($urandom_range(0, 9))
					0:       len5 = 5'd0;
					1:       len5 = 5'd1;
					2:       len5 = 5'd16;
					3:       len5 = 5'($urandom_range(17, 31));
					default: len5 = 5'($urandom_range(2, 8));
				endcase
				length_word = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : '0;
				length_word[LEN_REG_BITS-1:0] = len5;
			end
			program_keyword(low_word, high_word, length_word);
			filler = 8'($urandom_range(0, 255));
			repeat ($urandom_range(3, 8)) begin
				size = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
				make_stream(size, filler);
				send_stream($urandom_range(0, 3) == 0);
			end
			phase++;
		end

		wait_idle();
		$display("Scanned %0d bytes in %0d streams under %0d keyword settings.",
			bytes_sent, streams_sent, keywords_set);
		$display("Checked %0d match results and %0d stream totals.",
			matches_checked, totals_checked);
		if (fail_count == 0 && pending_count == 0) begin
			$display("PASS substring_match_scanner_core");
		end else begin
			$display("FAIL substring_match_scanner_core");
		end
		$finish;
	end

endmodule
